// ----- sv/mbst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbst_pkg
// Types and constants shared by the memory bus self-test sequencer.
// ----------------------------------------------------------------------------
package mbst_pkg;

  localparam int DATA_BITS = 8;

  localparam logic [1:0] CMD_DATA      = 2'd0;
  localparam logic [1:0] CMD_ADDR      = 2'd1;
  localparam logic [1:0] CMD_RANGE     = 2'd2;
  localparam logic [1:0] CMD_READ_DATA = 2'd3;

  localparam logic [7:0]  PAT            = 8'h55;
  localparam logic [7:0]  ANTIPAT        = 8'hAA;
  localparam logic [3:0]  ADDR_LINES_RST = 4'd11;
  localparam logic [15:0] WALK_END       = 16'(1 << DATA_BITS);

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] segment_in;
    logic [15:0] offset_in;
    logic [15:0] range_end;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] mem_segment;
    logic [15:0] mem_offset;
    logic [7:0]  mem_data;
    logic [15:0] fail_mask;
    logic        passed;
    logic        last;
  } out_item_t;

  // One burst of results: report first, walking writes, write, read, report last.
  typedef struct packed {
    logic [15:0] seg;
    logic        rep_first;
    logic        rep_last;
    logic [15:0] rep_off;
    logic [15:0] rep_mask;
    logic        rep_pass;
    logic [3:0]  walk_n;
    logic        has_wr;
    logic [15:0] wr_off;
    logic [7:0]  wr_data;
    logic        has_rd;
    logic [15:0] rd_off;
  } desc_t;

endpackage
`default_nettype wire

// ----- sv/mbst_chan_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbst_chan_if
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface mbst_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/mbst_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbst_step
// Test state and per-transaction decisions; produces one burst descriptor.
// ----------------------------------------------------------------------------
module mbst_step import mbst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  mbst_chan_if.sink       cmd,
  input  wire logic       desc_ready,
  output logic            desc_valid,
  output desc_t           desc
);

  logic [3:0]  address_lines;
  logic [1:0]  test_mode, test_mode_next;
  logic        active, active_next;
  logic [15:0] test_segment, test_segment_next;
  logic [15:0] test_base, test_base_next;
  logic [15:0] walk_bit, walk_bit_next;
  logic [15:0] fail_bits, fail_bits_next;
  logic [15:0] range_stop, range_stop_next;
  logic [15:0] range_addr, range_addr_next;

  in_item_t    item;
  logic        accept;
  logic [15:0] limit;
  logic [15:0] walk_shift;
  logic [15:0] fail_v;
  logic [15:0] addr_inc;

  assign item       = cmd.data;
  assign cmd.ready  = desc_ready;
  assign accept     = cmd.valid && cmd.ready;
  assign limit      = 16'h0001 << address_lines;
  assign walk_shift = {walk_bit[14:0], 1'b0};
  assign addr_inc   = range_addr + 16'd1;

  always_comb begin
    test_mode_next    = test_mode;
    active_next       = active;
    test_segment_next = test_segment;
    test_base_next    = test_base;
    walk_bit_next     = walk_bit;
    fail_bits_next    = fail_bits;
    range_stop_next   = range_stop;
    range_addr_next   = range_addr;
    fail_v            = fail_bits;
    desc              = '0;
    desc.seg          = test_segment;
    if (item.command != CMD_READ_DATA) begin
      test_mode_next    = item.command;
      test_segment_next = item.segment_in;
      test_base_next    = item.offset_in;
      fail_bits_next    = '0;
      active_next       = 1'b1;
      desc.seg          = item.segment_in;
      unique case (item.command)
        CMD_DATA: begin
          walk_bit_next = 16'd1;
          desc.has_wr   = 1'b1;
          desc.wr_off   = item.offset_in;
          desc.wr_data  = 8'h01;
          desc.has_rd   = 1'b1;
          desc.rd_off   = item.offset_in;
        end
        CMD_ADDR: begin
          walk_bit_next = 16'd1;
          desc.walk_n   = address_lines;
          desc.has_wr   = 1'b1;
          desc.wr_off   = item.offset_in;
          desc.wr_data  = ANTIPAT;
          if (address_lines != 4'd0) begin
            desc.has_rd = 1'b1;
            desc.rd_off = item.offset_in + 16'd1;
          end else begin
            active_next   = 1'b0;
            desc.rep_last = 1'b1;
            desc.rep_off  = item.offset_in;
            desc.rep_pass = 1'b1;
          end
        end
        default: begin
          range_addr_next = item.offset_in;
          range_stop_next = item.range_end;
          if (item.offset_in < item.range_end) begin
            desc.has_wr  = 1'b1;
            desc.wr_off  = item.offset_in;
            desc.wr_data = PAT;
            desc.has_rd  = 1'b1;
            desc.rd_off  = item.offset_in;
          end else begin
            active_next = 1'b0;
          end
        end
      endcase
    end else if (active) begin
      case (test_mode)
        CMD_DATA: begin
          fail_v         = (item.read_data != walk_bit[7:0]) ? (fail_bits | walk_bit)
                                                             : fail_bits;
          fail_bits_next = fail_v;
          walk_bit_next  = walk_shift;
          if (walk_shift == 16'd0 || walk_shift >= WALK_END) begin
            active_next   = 1'b0;
            desc.rep_last = 1'b1;
            desc.rep_off  = test_base;
            desc.rep_mask = fail_v;
            desc.rep_pass = (fail_v == 16'd0);
          end else begin
            desc.has_wr  = 1'b1;
            desc.wr_off  = test_base;
            desc.wr_data = walk_shift[7:0];
            desc.has_rd  = 1'b1;
            desc.rd_off  = test_base;
          end
        end
        CMD_ADDR: begin
          fail_v         = (item.read_data != PAT) ? (fail_bits | walk_bit) : fail_bits;
          fail_bits_next = fail_v;
          walk_bit_next  = walk_shift;
          if (walk_shift == 16'd0 || walk_shift >= limit) begin
            active_next   = 1'b0;
            desc.rep_last = 1'b1;
            desc.rep_off  = test_base;
            desc.rep_mask = fail_v;
            desc.rep_pass = (fail_v == 16'd0);
          end else begin
            desc.has_rd = 1'b1;
            desc.rd_off = test_base + walk_shift;
          end
        end
        CMD_RANGE: begin
          desc.rep_first  = 1'b1;
          desc.rep_off    = range_addr;
          desc.rep_pass   = (item.read_data == PAT);
          range_addr_next = addr_inc;
          if (addr_inc < range_stop && addr_inc != 16'd0) begin
            desc.has_wr  = 1'b1;
            desc.wr_off  = addr_inc;
            desc.wr_data = PAT;
            desc.has_rd  = 1'b1;
            desc.rd_off  = addr_inc;
          end else begin
            active_next = 1'b0;
          end
        end
        default: begin
          active_next = 1'b0;
        end
      endcase
    end
    desc_valid = accept && (desc.rep_first || desc.rep_last || desc.has_wr ||
                            desc.has_rd || desc.walk_n != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_lines <= ADDR_LINES_RST;
      test_mode     <= '0;
      active        <= 1'b0;
      test_segment  <= '0;
      test_base     <= '0;
      walk_bit      <= '0;
      fail_bits     <= '0;
      range_stop    <= '0;
      range_addr    <= '0;
    end else begin
      if (cfg_we) begin
        address_lines <= cfg_wdata;
      end
      if (accept) begin
        test_mode    <= test_mode_next;
        active       <= active_next;
        test_segment <= test_segment_next;
        test_base    <= test_base_next;
        walk_bit     <= walk_bit_next;
        fail_bits    <= fail_bits_next;
        range_stop   <= range_stop_next;
        range_addr   <= range_addr_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/mbst_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbst_emit
// Holds one burst descriptor and plays it out, one result per cycle while
// the receiver is not stalling, into the output register.
// ----------------------------------------------------------------------------
module mbst_emit import mbst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  desc_valid,
  input  wire desc_t desc,
  output logic       desc_ready,
  mbst_chan_if.source result
);

  typedef enum logic [2:0] {
    SEL_REP_FIRST,
    SEL_WALK,
    SEL_WR,
    SEL_RD,
    SEL_REP_LAST
  } sel_t;

  desc_t       cur;
  logic        rep_first_p;
  logic        wr_p;
  logic        rd_p;
  logic        rep_last_p;
  logic [3:0]  walk_left;
  logic [3:0]  walk_idx;
  logic        out_valid;
  out_item_t   out_item;

  sel_t        sel;
  logic        pend_any;
  logic        last_item;
  logic        advance;
  logic        load;
  logic [4:0]  pend_cnt;
  out_item_t   nxt;

  assign pend_any  = rep_first_p || wr_p || rd_p || rep_last_p || (walk_left != 4'd0);
  assign pend_cnt  = 5'(walk_left) + 5'(rep_first_p) + 5'(wr_p) + 5'(rd_p) + 5'(rep_last_p);
  assign last_item = (pend_cnt == 5'd1);
  assign advance   = pend_any && (!out_valid || result.ready);
  assign desc_ready = !pend_any || (advance && last_item);
  assign load      = desc_valid && desc_ready;

  assign result.valid = out_valid;
  assign result.data  = out_item;

  always_comb begin
    if (rep_first_p) begin
      sel = SEL_REP_FIRST;
    end else if (walk_left != 4'd0) begin
      sel = SEL_WALK;
    end else if (wr_p) begin
      sel = SEL_WR;
    end else if (rd_p) begin
      sel = SEL_RD;
    end else begin
      sel = SEL_REP_LAST;
    end
  end

  always_comb begin
    nxt             = '0;
    nxt.mem_segment = cur.seg;
    nxt.last        = last_item;
    unique case (sel)
      SEL_REP_FIRST, SEL_REP_LAST: begin
        nxt.kind       = KIND_REPORT;
        nxt.mem_offset = cur.rep_off;
        nxt.fail_mask  = cur.rep_mask;
        nxt.passed     = cur.rep_pass;
      end
      SEL_WALK: begin
        nxt.kind       = KIND_WRITE;
        nxt.mem_offset = cur.wr_off + (16'h0001 << walk_idx);
        nxt.mem_data   = PAT;
      end
      SEL_WR: begin
        nxt.kind       = KIND_WRITE;
        nxt.mem_offset = cur.wr_off;
        nxt.mem_data   = cur.wr_data;
      end
      SEL_RD: begin
        nxt.kind       = KIND_READ;
        nxt.mem_offset = cur.rd_off;
      end
      default: begin
        nxt.kind = KIND_REPORT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_first_p <= 1'b0;
      wr_p        <= 1'b0;
      rd_p        <= 1'b0;
      rep_last_p  <= 1'b0;
      walk_left   <= '0;
      walk_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        rep_first_p <= desc.rep_first;
        wr_p        <= desc.has_wr;
        rd_p        <= desc.has_rd;
        rep_last_p  <= desc.rep_last;
        walk_left   <= desc.walk_n;
        walk_idx    <= '0;
      end else if (advance) begin
        unique case (sel)
          SEL_REP_FIRST: rep_first_p <= 1'b0;
          SEL_WALK: begin
            walk_left <= walk_left - 4'd1;
            walk_idx  <= walk_idx + 4'd1;
          end
          SEL_WR:        wr_p       <= 1'b0;
          SEL_RD:        rd_p       <= 1'b0;
          SEL_REP_LAST:  rep_last_p <= 1'b0;
          default:       rep_last_p <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= desc;
    end
    if (advance) begin
      out_item <= nxt;
    end
  end

  a_report_once: assert property (@(posedge clk) disable iff (rst)
    !(rep_first_p && rep_last_p))
    else $error("both report slots pending");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (5'(walk_idx) + 5'(walk_left)) <= 5'd15)
    else $error("walking write index overrun");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |=> pend_any)
    else $error("empty burst loaded");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (advance && last_item && !desc_valid) |=> !pend_any)
    else $error("burst not drained after last result");

endmodule
`default_nettype wire

// ----- sv/memory_bus_self_test_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// memory_bus_self_test_top
// Memory bus self-test sequencer: data, address and range verify tests.
//
// cmd carries one transaction per start command or per returned read byte.
// result carries memory write/read requests and test reports; the final
// result caused by one cmd transaction has last set. cfg_we/cfg_wdata write
// the number of address lines probed by the address test (reset 11).
// A cmd transaction is decided in the cycle it is accepted and its burst is
// registered at that edge; the first result then moves from the burst
// register into the output register. Results leave at one per cycle while
// the receiver is not stalling; the burst register and output register let
// the next cmd transaction be accepted in the cycle the previous burst's
// last result is loaded. Transactions that cause no result load no burst.
// A stalled receiver holds the output register and, once the burst is
// queued, holds cmd.ready low. Reset returns the test to idle, clears all
// pending results and restores address_lines to 11.
// ----------------------------------------------------------------------------
module memory_bus_self_test_top import mbst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  mbst_chan_if.sink       cmd,
  mbst_chan_if.source     result
);

  logic  desc_valid;
  logic  desc_ready;
  desc_t desc;

  mbst_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .desc_ready (desc_ready),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  mbst_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready),
    .result     (result)
  );

endmodule
`default_nettype wire
